@@ hw/rtl/html_entity_decoder_defines.svh @@
// Assertion macros shared by the entity decoder RTL.
// Included by the modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef HTML_ENTITY_DECODER_DEFINES_SVH
`define HTML_ENTITY_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// generic form: explicit clock and active-low reset
`define HED_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// usual form: block clock and reset
`define HED_ASSERT(lbl, prop) \
  `HED_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`else

`define HED_ASSERT_CLK(lbl, clk, rst_n, prop)

`define HED_ASSERT(lbl, prop)

`endif

`endif

@@ hw/rtl/hed_pkg.sv @@
// Shared types for the entity decoder: the control part of a replay command.
// No dependencies.
`default_nettype none

package hed_pkg;

  // tail of a replay command: one optional byte after the held bytes
  typedef struct packed {
    logic       tail_valid;
    logic [7:0] tail_byte;
    logic       eos;
  } hed_tail_t;

endpackage

`default_nettype wire

@@ hw/rtl/hed_fifo.sv @@
// Two-entry command queue between the matcher and the replay sequencer.
// Standalone; head entry is visible without a pop.
`default_nettype none

module hed_fifo #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      head_o,
  output logic                  empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/hed_front.sv @@
// Front end of the entity decoder: takes input beats, tracks the entity match,
// keeps the held bytes and issues replay commands. Uses hed_pkg.
`default_nettype none

`include "html_entity_decoder_defines.svh"

module hed_front #(
  parameter int unsigned MaxDigits = 8,
  parameter int unsigned HoldCap   = ((MaxDigits + 3) > 5) ? (MaxDigits + 3) : 5
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [7:0]                     data_byte_i,
  input  wire logic                           end_of_stream_i,
  input  wire logic                           full_i,
  output logic                                push_o,
  output logic [$clog2(HoldCap + 1)-1:0]      cmd_cnt_o,
  output logic [HoldCap-1:0][7:0]             cmd_bytes_o,
  output hed_pkg::hed_tail_t                  cmd_tail_o
);

  import hed_pkg::*;

  localparam int unsigned CntW     = $clog2(HoldCap + 1);
  localparam int unsigned IdxW     = $clog2(HoldCap);
  localparam int unsigned DigW     = $clog2(MaxDigits + 1);
  localparam int          NumNames = 5;

  localparam logic [2:0] PhIdle   = 3'd0;
  localparam logic [2:0] PhAmp    = 3'd1;
  localparam logic [2:0] PhHash   = 3'd2;
  localparam logic [2:0] PhHashX  = 3'd3;
  localparam logic [2:0] PhDigits = 3'd4;
  localparam logic [2:0] PhNamed  = 3'd5;

  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChLx   = 8'h78;
  localparam logic [7:0] ChUx   = 8'h58;

  // &amp; &lt; &gt; &quot; &#x27;
  localparam logic [7:0] NameText [NumNames][8] = '{
    '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00, 8'h00, 8'h00},
    '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h26, 8'h23, 8'h78, 8'h32, 8'h37, 8'h3B, 8'h00, 8'h00}
  };
  localparam logic [2:0] NameLen [NumNames] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd6};
  localparam logic [7:0] NameOut [NumNames] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27};

  // {valid, value}
  function automatic logic [4:0] digit_of(input logic [7:0] b, input logic hex);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if (hex && ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  logic [2:0]            phase_q, phase_d;
  logic [HoldCap-1:0][7:0] held_q;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [7:0]            val_q, val_d;
  logic                  hex_q, hex_d;
  logic [DigW-1:0]       dig_q, dig_d;
  logic [NumNames-1:0]   alive_q, alive_d;

  logic                  accept;
  logic [NumNames-1:0]   hit, done;
  logic [7:0]            name_res;
  logic [4:0]            dg;
  logic                  dg_hex;
  logic [2:0]            np;
  logic [7:0]            nv;
  logic [7:0]            mul;
  logic                  nh;
  logic [DigW-1:0]       nc;
  logic                  num_done;
  logic                  hold_ok;
  logic                  wr_en;
  logic [IdxW-1:0]       wr_idx;
  logic [7:0]            wr_byte;
  hed_tail_t             tail;
  logic [CntW-1:0]       cmd_cnt;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  // named entity candidates still alive after this byte
  always_comb begin
    name_res = 8'h00;
    for (int i = 0; i < NumNames; i++) begin
      hit[i]  = alive_q[i] && (cnt_q < CntW'(NameLen[i])) &&
                (NameText[i][cnt_q[2:0]] == data_byte_i);
      done[i] = hit[i] && (cnt_q == CntW'(NameLen[i]) - CntW'(1));
    end
    for (int i = NumNames - 1; i >= 0; i--) begin
      if (done[i]) begin
        name_res = NameOut[i];
      end
    end
  end

  // numeric reference tracking
  always_comb begin
    dg_hex   = (phase_q == PhHashX) ? 1'b1 : ((phase_q == PhHash) ? 1'b0 : hex_q);
    dg       = digit_of(data_byte_i, dg_hex);
    mul      = hex_q ? {val_q[3:0], 4'h0} : ({val_q[4:0], 3'b000} + {val_q[6:0], 1'b0});
    np       = PhNamed;
    nv       = val_q;
    nh       = hex_q;
    nc       = dig_q;
    num_done = 1'b0;
    unique case (phase_q)
      PhAmp: begin
        if (data_byte_i == ChHash) begin
          np = PhHash;
        end
      end
      PhHash: begin
        if (data_byte_i == ChLx || data_byte_i == ChUx) begin
          np = PhHashX;
          nh = 1'b1;
        end else if (dg[4]) begin
          np = PhDigits;
          nv = {4'h0, dg[3:0]};
          nc = DigW'(1);
        end
      end
      PhHashX: begin
        if (dg[4]) begin
          np = PhDigits;
          nv = {4'h0, dg[3:0]};
          nc = DigW'(1);
        end
      end
      PhDigits: begin
        if (data_byte_i == ChSemi) begin
          num_done = 1'b1;
        end else if (dg[4] && dig_q < DigW'(MaxDigits)) begin
          np = PhDigits;
          nv = mul + {4'h0, dg[3:0]};
          nc = dig_q + DigW'(1);
        end
      end
      default: begin
      end
    endcase
    hold_ok = ((np != PhNamed) || (|hit)) && (cnt_q < CntW'(HoldCap));
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    val_d   = val_q;
    hex_d   = hex_q;
    dig_d   = dig_q;
    alive_d = alive_q;
    wr_en   = 1'b0;
    wr_idx  = cnt_q[IdxW-1:0];
    wr_byte = data_byte_i;
    cmd_cnt = '0;
    tail.tail_valid = 1'b0;
    tail.tail_byte  = data_byte_i;
    tail.eos        = end_of_stream_i;

    if (accept) begin
      if (phase_q == PhIdle || done != '0 || num_done || !hold_ok) begin
        // any held bytes go out first on a break
        if (phase_q != PhIdle && done == '0 && !num_done) begin
          cmd_cnt = cnt_q;
        end
        phase_d = PhIdle;
        cnt_d   = '0;
        val_d   = 8'h00;
        hex_d   = 1'b0;
        dig_d   = '0;
        if (phase_q != PhIdle && (done != '0 || num_done)) begin
          tail.tail_valid = 1'b1;
          tail.tail_byte  = (done != '0) ? name_res : val_q;
        end else if (data_byte_i == ChAmp) begin
          if (end_of_stream_i) begin
            tail.tail_valid = 1'b1;
          end else begin
            phase_d = PhAmp;
            cnt_d   = CntW'(1);
            alive_d = '1;
            wr_en   = 1'b1;
            wr_idx  = '0;
            wr_byte = ChAmp;
          end
        end else begin
          tail.tail_valid = 1'b1;
        end
      end else if (end_of_stream_i) begin
        // byte would be held, but the stream ends: flush everything literally
        cmd_cnt         = cnt_q;
        tail.tail_valid = 1'b1;
        phase_d = PhIdle;
        cnt_d   = '0;
        val_d   = 8'h00;
        hex_d   = 1'b0;
        dig_d   = '0;
      end else begin
        wr_en   = 1'b1;
        cnt_d   = cnt_q + CntW'(1);
        phase_d = np;
        val_d   = nv;
        hex_d   = nh;
        dig_d   = nc;
        alive_d = hit;
      end
    end
  end

  assign push_o      = accept && ((cmd_cnt != '0) || tail.tail_valid);
  assign cmd_cnt_o   = cmd_cnt;
  assign cmd_bytes_o = held_q;
  assign cmd_tail_o  = tail;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      cnt_q   <= '0;
      val_q   <= 8'h00;
      hex_q   <= 1'b0;
      dig_q   <= '0;
      alive_q <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      val_q   <= val_d;
      hex_q   <= hex_d;
      dig_q   <= dig_d;
      alive_q <= alive_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      held_q[wr_idx] <= wr_byte;
    end
  end

  `HED_ASSERT(a_idle_empty, (phase_q == PhIdle) |-> (cnt_q == '0))
  `HED_ASSERT(a_busy_holds, (phase_q != PhIdle) |-> (cnt_q != '0))
  `HED_ASSERT(a_cnt_cap, cnt_q <= CntW'(HoldCap))

endmodule

`default_nettype wire

@@ hw/rtl/hed_back.sv @@
// Back end of the entity decoder: walks the head command of the queue and
// emits its bytes through the output register. Uses hed_pkg.
`default_nettype none

`include "html_entity_decoder_defines.svh"

module hed_back #(
  parameter int unsigned HoldCap = 11
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         empty_i,
  output logic                              pop_o,
  input  wire logic [$clog2(HoldCap + 1)-1:0] head_cnt_i,
  input  wire logic [HoldCap-1:0][7:0]      head_bytes_i,
  input  wire hed_pkg::hed_tail_t           head_tail_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [7:0]                        out_byte_o,
  output logic                              run_last_o,
  output logic                              stream_done_o
);

  import hed_pkg::*;

  localparam int unsigned CntW = $clog2(HoldCap + 1);
  localparam int unsigned SelW = $clog2(HoldCap);

  logic [CntW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q;
  logic            run_last_q;
  logic            stream_done_q;

  logic            emit;
  logic            is_last;
  logic [7:0]      cur_byte;

  assign emit     = !empty_i && (!out_valid_q || !out_stall_i);
  assign cur_byte = (idx_q < head_cnt_i) ? head_bytes_i[idx_q[SelW-1:0]]
                                         : head_tail_i.tail_byte;
  assign is_last  = head_tail_i.tail_valid ? (idx_q == head_cnt_i)
                                           : (idx_q == head_cnt_i - CntW'(1));
  assign pop_o    = emit && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      idx_d       = is_last ? '0 : idx_q + CntW'(1);
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q    <= cur_byte;
      run_last_q    <= is_last;
      stream_done_q <= is_last && head_tail_i.eos;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign run_last_o    = run_last_q;
  assign stream_done_o = stream_done_q;

  `HED_ASSERT(a_idx_range, !empty_i |-> (idx_q <= head_cnt_i))
  `HED_ASSERT(a_idx_rest, empty_i |-> (idx_q == '0))
  `HED_ASSERT(a_pop_marks_last, pop_o |=> (out_valid_o && run_last_o))

endmodule

`default_nettype wire

@@ hw/rtl/html_entity_decoder.sv @@
// Streaming HTML entity decoder, top level.
// Instantiates hed_front, hed_fifo and hed_back; uses hed_pkg.
//
// Input channel: one text byte per beat (data_byte_i, end_of_stream_i), taken at an
// edge with in_valid_i high and in_stall_o low. Output channel: one byte per beat
// (out_byte_o, run_last_o, stream_done_o) under out_valid_o / out_stall_i.
// Decodes &amp; &lt; &gt; &quot; &#x27; and &#ddd; / &#xhh; (low 8 bits of the value,
// at most MaxDigits digits). Bytes of a possible entity are held; on a mismatch or at
// end of stream they are replayed literally, then the breaking byte is rescanned.
// run_last_o marks the last output beat caused by one input beat; stream_done_o marks
// the last output beat of an input beat that carried end_of_stream_i.
// Timing: the front classifies a byte in the cycle it is taken; its replay command
// enters a two-entry queue; the back emits one output beat per cycle from the queue
// head into the output register unless a stalled beat holds it. Pass-through text runs
// at 1 byte per cycle while the output does not stall; an input beat that causes n
// results (n up to HoldCap + 1) holds the back until all n are out; the input stalls
// once the queue holds two commands. A beat that is only held makes no output.
// Reset: all match state clears to idle, the queue empties, out_valid_o drops.
// A stalled output holds its beat; the queue keeps accepting until full.
`default_nettype none

module html_entity_decoder #(
  parameter int unsigned MaxDigits = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       end_of_stream_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic            stream_done_o
);

  import hed_pkg::*;

  // longest hold: "&#x" plus all digits, or the longest name prefix
  localparam int unsigned HoldCap = ((MaxDigits + 3) > 5) ? (MaxDigits + 3) : 5;
  localparam int unsigned CntW    = $clog2(HoldCap + 1);
  localparam int unsigned TailW   = $bits(hed_tail_t);
  localparam int unsigned BytesW  = HoldCap * 8;
  localparam int unsigned EntryW  = CntW + BytesW + TailW;

  logic                    push;
  logic                    full;
  logic                    pop;
  logic                    empty;
  logic [CntW-1:0]         cmd_cnt;
  logic [HoldCap-1:0][7:0] cmd_bytes;
  hed_tail_t               cmd_tail;
  logic [EntryW-1:0]       head;
  logic [CntW-1:0]         head_cnt;
  logic [HoldCap-1:0][7:0] head_bytes;
  hed_tail_t               head_tail;

  // front: matcher and held-byte store
  hed_front #(
    .MaxDigits (MaxDigits),
    .HoldCap   (HoldCap)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .full_i          (full),
    .push_o          (push),
    .cmd_cnt_o       (cmd_cnt),
    .cmd_bytes_o     (cmd_bytes),
    .cmd_tail_o      (cmd_tail)
  );

  // command queue: {held count, held bytes, tail}
  hed_fifo #(
    .Width (EntryW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({cmd_cnt, cmd_bytes, cmd_tail}),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  assign head_cnt   = head[EntryW-1 -: CntW];
  assign head_bytes = head[TailW +: BytesW];
  assign head_tail  = head[TailW-1:0];

  // back: replay sequencer and output register
  hed_back #(
    .HoldCap (HoldCap)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .pop_o         (pop),
    .head_cnt_i    (head_cnt),
    .head_bytes_i  (head_bytes),
    .head_tail_i   (head_tail),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .stream_done_o (stream_done_o)
  );

endmodule

`default_nettype wire
